FILE: rtl/assert_macros.svh
// assertion macros shared by the box filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/bfm_pkg.sv
// shared types and constants for the box filter mip downsampler
`timescale 1ns / 1ps
package bfm_pkg;

  localparam int unsigned PIX_W      = 32;
  localparam int unsigned NCHAN      = 4;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned SUM_W      = 10;
  localparam int unsigned TOT_W      = 11;
  localparam int unsigned SRC_W_W    = 13;
  localparam int unsigned SRC_H_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned FIFO_DEPTH = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_MODE = 2'd2;

  // four channel pair sums, r in the low lane
  typedef logic [NCHAN-1:0][SUM_W-1:0] line_t;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_DIRECT = 2'd2
  } op_t;

  typedef struct packed {
    op_t   op;
    logic  last;
    logic  vol;
    line_t hs;
  } cmd_t;

  typedef struct packed {
    logic [SRC_W_W-1:0] width;
    logic [SRC_H_W-1:0] height;
    logic               volume_mode;
  } cfg_t;

endpackage

FILE: rtl/bfm_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module bfm_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/bfm_fifo.sv
// short command queue between front and back
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bfm_fifo #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             valid
);

  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PW-1:0]    LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign valid   = (count_r != '0);
  assign full    = (count_r == FULL_CNT);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `ASSERT_IMPLIES(a_fifo_count_bound, clk, rst_n, 1'b1, count_r <= FULL_CNT)

endmodule

FILE: rtl/bfm_front.sv
// front end: position counters, pair sums and command classification
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bfm_front #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bfm_pkg::cfg_t                      cfg,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bfm_pkg::PIX_W-1:0]          pixel_one,
  input  logic [bfm_pkg::PIX_W-1:0]          pixel_two,
  output logic                               push,
  output bfm_pkg::cmd_t                      cmd,
  output logic [(((MAX_WIDTH + 1) / 2 > 1) ? $clog2((MAX_WIDTH + 1) / 2) : 1)-1:0] addr,
  input  logic                               full
);

  localparam int unsigned LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int unsigned AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = (CW + 1 > bfm_pkg::SRC_W_W) ? CW + 1 : bfm_pkg::SRC_W_W;
  localparam int unsigned HW = bfm_pkg::SRC_H_W;
  localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);

  logic [CW-1:0] col_r, col_nxt, col_use, xi_full;
  logic [HW-1:0] row_r, row_nxt, row_use, h_eff;
  logic [bfm_pkg::NCHAN-1:0][bfm_pkg::CHAN_W:0] pair_r, s;
  logic [WW-1:0] w_raw, w_eff, col_inc;
  logic [HW:0]   row_inc;
  logic          w_one, h_one, end_row, end_lvl, hdone, act, acc;
  logic          last_x, last_y, row_is_last;
  bfm_pkg::op_t  op;
  bfm_pkg::line_t hs;

  // clamp the configured size
  assign w_raw = WW'(cfg.width);
  assign w_eff = (w_raw == '0) ? WW'(1) : ((w_raw > MAXW) ? MAXW : w_raw);
  assign h_eff = (cfg.height == '0) ? HW'(1) : cfg.height;
  assign w_one = (w_eff == WW'(1));
  assign h_one = (h_eff == HW'(1));

  // counters left beyond a new size wrap before use
  assign col_use = (WW'(col_r) >= w_eff) ? '0 : col_r;
  assign row_use = (row_r >= h_eff) ? '0 : row_r;
  assign col_inc = WW'(col_use) + WW'(1);
  assign row_inc = {1'b0, row_use} + (HW + 1)'(1);
  assign end_row = (col_inc >= w_eff);
  assign end_lvl = end_row && (row_inc >= {1'b0, h_eff});
  assign col_nxt = end_row ? '0 : col_inc[CW-1:0];
  assign row_nxt = end_row ? (end_lvl ? '0 : row_inc[HW-1:0]) : row_use;

  always_comb begin
    for (int c = 0; c < bfm_pkg::NCHAN; c++) begin
      s[c] = {1'b0, pixel_one[c*bfm_pkg::CHAN_W +: bfm_pkg::CHAN_W]}
           + (cfg.volume_mode ? {1'b0, pixel_two[c*bfm_pkg::CHAN_W +: bfm_pkg::CHAN_W]}
                              : (bfm_pkg::CHAN_W + 1)'(0));
      hs[c] = w_one ? {s[c], 1'b0} : ({1'b0, pair_r[c]} + {1'b0, s[c]});
    end
  end

  assign hdone       = w_one || col_use[0];
  assign xi_full     = col_use >> 1;
  assign last_x      = w_one || ((WW'(xi_full) + WW'(1)) == (w_eff >> 1));
  assign last_y      = h_one || (({1'b0, row_use >> 1} + (HW + 1)'(1)) == {1'b0, h_eff >> 1});
  assign row_is_last = (row_use == h_eff - HW'(1));

  // what the back end has to do with this word
  always_comb begin
    act = 1'b0;
    op  = bfm_pkg::OP_WRITE;
    if (hdone) begin
      if (h_one) begin
        act = 1'b1;
        op  = bfm_pkg::OP_DIRECT;
      end else if (!row_use[0]) begin
        act = !row_is_last;
        op  = bfm_pkg::OP_WRITE;
      end else begin
        act = 1'b1;
        op  = bfm_pkg::OP_READ;
      end
    end
  end

  assign in_ready = !full;
  assign acc      = in_valid && in_ready;
  assign push     = acc && act;
  assign addr     = xi_full[AW-1:0];
  assign cmd.op   = op;
  assign cmd.last = last_x && last_y;
  assign cmd.vol  = cfg.volume_mode;
  assign cmd.hs   = hs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      pair_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (!w_one && !col_use[0]) begin
        pair_r <= s;
      end
    end
  end

  `ASSERT_NEXT(a_row_wrap, clk, rst_n, acc && end_row, col_r == '0)
  `ASSERT_NEXT(a_col_step, clk, rst_n, acc && !end_row, col_r != '0)

endmodule

FILE: rtl/bfm_back.sv
// back end: line buffer access, final sum, rounding and output register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bfm_back #(
  parameter int unsigned LINE_DEPTH = 2048
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  input  bfm_pkg::cmd_t                         q_cmd,
  input  logic [((LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1)-1:0] q_addr,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [bfm_pkg::PIX_W-1:0]             out_pixel,
  output logic                                  out_last
);

  localparam int unsigned TW = bfm_pkg::TOT_W;

  bfm_pkg::cmd_t  s1_cmd_r;
  bfm_pkg::line_t rd_data, other;
  logic           s1_v_r, s1_v_nxt, out_v_r, out_v_nxt;
  logic           s1_adv, s1_free, is_wr, s1_load;
  logic [bfm_pkg::PIX_W-1:0] pix_nxt, out_pix_r;
  logic           out_last_r;
  logic [bfm_pkg::NCHAN-1:0][TW-1:0] tot;

  assign s1_adv  = s1_v_r && (!out_v_r || out_ready);
  assign s1_free = !s1_v_r || s1_adv;
  assign is_wr   = (q_cmd.op == bfm_pkg::OP_WRITE);
  // writes retire at once, reads and direct commands wait for the stage behind the ram
  assign q_pop   = q_valid && (is_wr || s1_free);
  assign s1_load = q_pop && !is_wr;

  bfm_ram #(
    .WIDTH ($bits(bfm_pkg::line_t)),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (q_pop && is_wr),
    .waddr (q_addr),
    .wdata (q_cmd.hs),
    .re    (s1_load),
    .raddr (q_addr),
    .rdata (rd_data)
  );

  always_comb begin
    case (s1_cmd_r.op)
      bfm_pkg::OP_READ: other = rd_data;
      default:          other = s1_cmd_r.hs;
    endcase
    for (int c = 0; c < bfm_pkg::NCHAN; c++) begin
      tot[c] = {1'b0, other[c]} + {1'b0, s1_cmd_r.hs[c]}
             + (s1_cmd_r.vol ? TW'(4) : TW'(2));
      pix_nxt[c*bfm_pkg::CHAN_W +: bfm_pkg::CHAN_W] =
        s1_cmd_r.vol ? tot[c][TW-1:3] : tot[c][TW-2:2];
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_load) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_cmd_r <= q_cmd;
    end
    if (s1_adv) begin
      out_pix_r  <= pix_nxt;
      out_last_r <= s1_cmd_r.last;
    end
  end

  assign out_valid = out_v_r;
  assign out_pixel = out_pix_r;
  assign out_last  = out_last_r;

  `ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_v_r && out_v_r && !out_ready, s1_v_r)
  `ASSERT_IMPLIES(a_s1_no_write, clk, rst_n, s1_v_r, s1_cmd_r.op != bfm_pkg::OP_WRITE)

endmodule

FILE: rtl/box_filter_mip_downsample_rgba8_unit.sv
// top level of the 2x2 (2x2x2 in volume mode) box filter mip downsampler for rgba8
// The source level streams in raster order, one word per pixel: pixel_one
// of the first slice in in_tdata[31:0] and, in volume mode, the pixel at
// the same place in the paired slice in in_tdata[63:32]. One destination
// pixel leaves per completed 2x2 block, rounded as (sum+2)/4 per channel
// or (sum+4)/8 in volume mode, with out_tlast on the last one of the
// level. A dimension of one is kept rather than halved, each pixel counted twice;
// a trailing odd column or row is consumed and dropped. One input word is taken
// every clock while the queue is not full, and one result can leave every clock
// while out_tready is high; a result passes through the queue, the registered
// read of the line buffer ram and the output register. The line buffer holds
// (MAX_WIDTH+1)/2 entries of four 10-bit channel sums and needs no clearing
// pass: every entry is written on an even row before it is read. Registers:
// 0 src_width (13 bits), 1 src_height (16 bits), 2 volume_mode; the user must
// write them through the cfg channel only while the block is idle (not enforced).
`timescale 1ns / 1ps
module box_filter_mip_downsample_rgba8_unit #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [2*bfm_pkg::PIX_W-1:0]      in_tdata,   // pixel_one [31:0], pixel_two [63:32]
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bfm_pkg::PIX_W-1:0]        out_tdata,  // out_pixel [31:0]
  output logic                             out_tlast,  // level_done
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bfm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int unsigned AW   = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned QW   = $bits(bfm_pkg::cmd_t) + AW;

  bfm_pkg::cfg_t cfg_r;
  bfm_pkg::cmd_t f_cmd, q_cmd;
  logic [AW-1:0] f_addr, q_addr;
  logic          f_push, q_full, q_valid, q_pop;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width       <= bfm_pkg::SRC_W_W'(1);
      cfg_r.height      <= bfm_pkg::SRC_H_W'(1);
      cfg_r.volume_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bfm_pkg::REG_SRC_WIDTH:   cfg_r.width       <= cfg_data[bfm_pkg::SRC_W_W-1:0];
        bfm_pkg::REG_SRC_HEIGHT:  cfg_r.height      <= cfg_data[bfm_pkg::SRC_H_W-1:0];
        bfm_pkg::REG_VOLUME_MODE: cfg_r.volume_mode <= cfg_data[0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // front: counters, horizontal pairing, classification
  bfm_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .pixel_one (in_tdata[bfm_pkg::PIX_W-1:0]),
    .pixel_two (in_tdata[2*bfm_pkg::PIX_W-1:bfm_pkg::PIX_W]),
    .push      (f_push),
    .cmd       (f_cmd),
    .addr      (f_addr),
    .full      (q_full)
  );

  // short queue decoupling the two halves
  bfm_fifo #(
    .WIDTH (QW),
    .DEPTH (bfm_pkg::FIFO_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata ({f_cmd, f_addr}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata ({q_cmd, q_addr}),
    .valid (q_valid)
  );

  // back: line buffer, vertical sum, rounding, output register
  bfm_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_addr    (q_addr),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pixel (out_tdata),
    .out_last  (out_tlast)
  );

endmodule
